[rtl/cdss_pkg.sv]
package cdss_pkg;

	localparam int VALUE_W = 14;
	localparam int SEG_W   = 8;
	localparam int EN_W    = 4;
	localparam int CHAR_W  = 8;
	localparam int OP_W    = 2;

	typedef logic [3:0] bcd_t;

	// event kinds
	localparam logic [OP_W-1:0] OP_COUNT = 2'd0;
	localparam logic [OP_W-1:0] OP_SCAN  = 2'd1;
	localparam logic [OP_W-1:0] OP_CHAR  = 2'd2;
	localparam logic [OP_W-1:0] OP_IDLE  = 2'd3;

	localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0]  CHAR_NINE  = 8'h39;
	localparam bcd_t               DIGIT_NINE = 4'd9;
	localparam logic [SEG_W-1:0]   SEG_BLANK  = 8'hFF;
	localparam logic [VALUE_W-1:0] IDLE_LIMIT_RESET = 14'd1000;
	localparam logic [VALUE_W-1:0] IDLE_MAX   = 14'h3FFF;

	// active-low segments, common anode
	function automatic logic [SEG_W-1:0] seg_pattern(input bcd_t d);
		logic [SEG_W-1:0] p;
		case (d)
			4'd0:    p = 8'hC0;
			4'd1:    p = 8'hF9;
			4'd2:    p = 8'hA4;
			4'd3:    p = 8'hB0;
			4'd4:    p = 8'h99;
			4'd5:    p = 8'h92;
			4'd6:    p = 8'h82;
			4'd7:    p = 8'hF8;
			4'd8:    p = 8'h80;
			4'd9:    p = 8'h90;
			4'd10:   p = 8'hC0;
			4'd11:   p = 8'hF9;
			4'd12:   p = 8'hA4;
			4'd13:   p = 8'hB0;
			4'd14:   p = 8'h99;
			default: p = 8'h92;
		endcase
		return p;
	endfunction

	// 10**k, wrapped to the value width
	function automatic logic [VALUE_W-1:0] pow10_mod(input int k);
		logic [VALUE_W-1:0] p;
		p = 14'd1;
		for (int i = 0; i < k; i++) begin
			p = 14'(p * 14'd10);
		end
		return p;
	endfunction

endpackage

[rtl/countdown_seven_segment_serial_load.sv]
// Decimal countdown for multiplexed common-anode seven-segment digits, loadable
// over a serial link. Each input transfer is one event: a count tick decrements
// the value (zero wraps to all nines), a scan tick lights the next digit and
// latches its active-low segment pattern, a received character is buffered when
// it is a decimal digit (up to DIGITS of them, first received is most
// significant) and restarts the idle count, and an idle tick advances the idle
// count, loading the buffered digits as the new value on the tick that makes the
// count equal idle_limit if any digits are buffered. Every event gives one result
// transfer with the driven segments and enable, the value after the event, and a
// load flag. Throughput is one event per clock while the output is not stalled:
// the event sits in an input register while the state update and the
// BCD-to-binary view of the value are worked out, and the result then lands in
// the output register. A stalled output holds both stages; nothing else limits
// the rate. idle_limit is to be written through the cfg port only while no
// event is in flight; the block itself does not enforce this. It resets to 1000.
module countdown_seven_segment_serial_load
	import cdss_pkg::*;
#(
	parameter int DIGITS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [VALUE_W-1:0] cfg_data,
	// event channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [OP_W-1:0]    opcode,
	input  logic [CHAR_W-1:0]  rx_char,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [SEG_W-1:0]   segment_pattern,
	output logic [EN_W-1:0]    digit_enable,
	output logic [VALUE_W-1:0] shown_value,
	output logic               loaded
);

	localparam int PW  = (DIGITS > 1) ? $clog2(DIGITS) : 1;	// scan position
	localparam int PW1 = PW + 1;
	localparam int CW  = $clog2(DIGITS + 1);				// buffered digit count

	// configuration
	logic [VALUE_W-1:0] idle_limit_q;

	// input stage
	logic              s1_valid_q;
	logic [OP_W-1:0]   op_s1;
	logic [CHAR_W-1:0] ch_s1;

	// block state
	bcd_t              value_q [DIGITS];
	bcd_t              entry_q [DIGITS];	// newest digit at index 0
	logic [CW-1:0]     entry_cnt_q;
	logic [PW-1:0]     pos_q;
	logic [VALUE_W-1:0] idle_q;
	logic [SEG_W-1:0]  lit_pat_q;
	logic [EN_W-1:0]   lit_en_q;

	// result register
	logic               out_valid_q;
	logic [SEG_W-1:0]   seg_q;
	logic [EN_W-1:0]    en_q;
	logic [VALUE_W-1:0] shown_q;
	logic               loaded_q;

	// next-state terms
	logic               advance;
	logic               fire;
	bcd_t               dec_digits [DIGITS];
	bcd_t               ld_digits  [DIGITS];
	bcd_t               nxt_digits [DIGITS];
	logic [DIGITS*4-1:0] nxt_flat;
	logic [VALUE_W-1:0] nxt_value;
	logic [SEG_W-1:0]   nxt_pat;
	logic [EN_W-1:0]    scan_en;
	logic [PW1-1:0]     pos_inc;
	logic [PW-1:0]      pos_nxt;
	logic               is_digit;
	logic               buf_room;
	logic               idle_run;
	logic [VALUE_W-1:0] idle_inc;
	logic               load_hit;

	assign cfg_ready = 1'b1;

	// the whole pipe moves together; the output register parts the two sides
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !s1_valid_q || advance;
	assign fire     = s1_valid_q && advance;

	assign out_valid       = out_valid_q;
	assign segment_pattern = seg_q;
	assign digit_enable    = en_q;
	assign shown_value     = shown_q;
	assign loaded          = loaded_q;

	// decrement with borrow ripple: all zeros fall through to all nines
	always_comb begin
		logic borrow;
		borrow = 1'b1;
		for (int k = 0; k < DIGITS; k++) begin
			dec_digits[k] = value_q[k];
			if (borrow) begin
				if (value_q[k] != 4'd0) begin
					dec_digits[k] = value_q[k] - 4'd1;
					borrow = 1'b0;
				end else begin
					dec_digits[k] = DIGIT_NINE;
				end
			end
		end
	end

	// buffered digits as a value; slots past the count read as zero
	always_comb begin
		for (int k = 0; k < DIGITS; k++) begin
			ld_digits[k] = (CW'(k) < entry_cnt_q) ? entry_q[k] : 4'd0;
		end
	end

	assign is_digit = (ch_s1 >= CHAR_ZERO) && (ch_s1 <= CHAR_NINE);
	assign buf_room = entry_cnt_q < CW'(DIGITS);

	// idle count saturates one past the limit or at IDLE_MAX, so a load fires at most once per idle spell
	assign idle_run = (idle_q != IDLE_MAX) && (idle_q <= idle_limit_q);
	assign idle_inc = idle_q + 14'd1;
	assign load_hit = (op_s1 == OP_IDLE) && idle_run && (idle_inc == idle_limit_q) &&
		(entry_cnt_q != '0);

	// scan
	assign pos_inc = {1'b0, pos_q} + PW1'(1);
	assign pos_nxt = (pos_inc >= PW1'(DIGITS)) ? '0 : pos_inc[PW-1:0];

	always_comb begin
		for (int i = 0; i < EN_W; i++) begin
			scan_en[i] = (32'(pos_q) == i);
		end
	end

	always_comb begin
		nxt_pat = lit_pat_q;
		for (int k = 0; k < DIGITS; k++) begin
			nxt_digits[k] = value_q[k];
		end
		case (op_s1)
			OP_COUNT: begin
				for (int k = 0; k < DIGITS; k++) begin
					nxt_digits[k] = dec_digits[k];
				end
			end
			OP_SCAN: begin
				nxt_pat = seg_pattern(value_q[pos_q]);
			end
			OP_IDLE: begin
				if (load_hit) begin
					for (int k = 0; k < DIGITS; k++) begin
						nxt_digits[k] = ld_digits[k];
					end
				end
			end
			default: begin
			end
		endcase
		for (int k = 0; k < DIGITS; k++) begin
			nxt_flat[k*4 +: 4] = nxt_digits[k];
		end
	end

	cdss_bcd_bin #(
		.DIGITS(DIGITS)
	) u_bcd_bin (
		.digits(nxt_flat),
		.value (nxt_value)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_limit_q <= IDLE_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			idle_limit_q <= cfg_data;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1 <= opcode;
			ch_s1 <= rx_char;
		end
	end

	// block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIGITS; k++) begin
				value_q[k] <= 4'd0;
			end
			entry_cnt_q <= '0;
			pos_q       <= '0;
			idle_q      <= '0;
			lit_pat_q   <= SEG_BLANK;
			lit_en_q    <= '0;
		end else if (fire) begin
			for (int k = 0; k < DIGITS; k++) begin
				value_q[k] <= nxt_digits[k];
			end
			case (op_s1)
				OP_SCAN: begin
					lit_pat_q <= nxt_pat;
					lit_en_q  <= scan_en;
					pos_q     <= pos_nxt;
				end
				OP_CHAR: begin
					idle_q <= '0;
					if (is_digit && buf_room) begin
						entry_cnt_q <= entry_cnt_q + CW'(1);
					end
				end
				OP_IDLE: begin
					if (idle_run) begin
						idle_q <= idle_inc;
					end
					if (load_hit) begin
						entry_cnt_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// entry buffer shifts; stale slots are masked by the count
	always_ff @(posedge clk) begin
		if (fire && (op_s1 == OP_CHAR) && is_digit && buf_room) begin
			entry_q[0] <= 4'(ch_s1 - CHAR_ZERO);
			for (int k = 1; k < DIGITS; k++) begin
				entry_q[k] <= entry_q[k-1];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			seg_q    <= nxt_pat;
			en_q     <= (op_s1 == OP_SCAN) ? scan_en : lit_en_q;
			shown_q  <= nxt_value;
			loaded_q <= load_hit;
		end
	end

	// a result flagged as a load leaves the buffer empty
	a_load_empties: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && loaded_q |-> entry_cnt_q == '0)
		else $error("load result with digits still buffered");

	// at most one digit lit
	a_enable_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(lit_en_q))
		else $error("more than one digit enabled");

	// scan position and buffer count stay in range
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(pos_q) < DIGITS) && (32'(entry_cnt_q) <= DIGITS))
		else $error("scan position or buffer count out of range");

endmodule

[rtl/cdss_bcd_bin.sv]
module cdss_bcd_bin
	import cdss_pkg::*;
#(
	parameter int DIGITS = 4
) (
	input  logic [DIGITS*4-1:0] digits,
	output logic [VALUE_W-1:0]  value
);

	// weighted sum of the decimal digits, kept modulo 2**VALUE_W
	always_comb begin
		logic [VALUE_W-1:0] acc;
		acc = '0;
		for (int k = 0; k < DIGITS; k++) begin
			acc = 14'(acc + 14'(digits[k*4 +: 4] * pow10_mod(k)));
		end
		value = acc;
	end

endmodule

[test/countdown_display_checker.sv]
`timescale 1ns / 100ps

module countdown_display_checker
	import cdss_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [VALUE_W-1:0] cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [OP_W-1:0]    opcode,
	input  logic [CHAR_W-1:0]  rx_char,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [SEG_W-1:0]   segment_pattern,
	input  logic [EN_W-1:0]    digit_enable,
	input  logic [VALUE_W-1:0] shown_value,
	input  logic               loaded,
	output int                 fail_count,
	output int                 results_waiting,
	output int                 loads_seen
);

	localparam int DIGIT_N = 4;

	// active-low glyphs, index is the digit
	localparam logic [9:0][SEG_W-1:0] GLYPHS = {
		8'h90, 8'h80, 8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
	};

	typedef struct packed {
		logic [SEG_W-1:0]   seg;
		logic [EN_W-1:0]    en;
		logic [VALUE_W-1:0] value;
		logic               load;
	} display_t;

	display_t           display_q[$];
	display_t           want;
	display_t           got;

	logic [VALUE_W-1:0] idle_limit;
	bcd_t               count_digit [DIGIT_N];
	bcd_t               entry_digit [DIGIT_N];
	int                 entry_len;
	logic [1:0]         scan_pos;
	logic [VALUE_W-1:0] idle_ticks;
	logic [SEG_W-1:0]   lit_seg;
	logic [EN_W-1:0]    lit_en;

	// advances the display state by one event and returns what it shows
	function automatic display_t predict_display(input logic [OP_W-1:0] op,
			input logic [CHAR_W-1:0] ch);
		display_t r;
		logic     borrow;
		logic     all_zero;
		int       v;
		r.load = 1'b0;
		case (op)
			OP_COUNT: begin
				all_zero = 1'b1;
				for (int k = 0; k < DIGIT_N; k++)
					if (count_digit[k] != 0) all_zero = 1'b0;
				// from zero every digit borrows, leaving all nines
				borrow = 1'b1;
				for (int k = 0; k < DIGIT_N; k++) begin
					if (borrow) begin
						if (all_zero || count_digit[k] == 0) begin
							count_digit[k] = DIGIT_NINE;
						end else begin
							count_digit[k] = count_digit[k] - 4'd1;
							borrow = 1'b0;
						end
					end
				end
			end
			OP_SCAN: begin
				lit_seg  = GLYPHS[count_digit[scan_pos]];
				lit_en   = EN_W'(1) << scan_pos;
				scan_pos = scan_pos + 2'd1;
			end
			OP_CHAR: begin
				idle_ticks = '0;
				if (ch >= CHAR_ZERO && ch <= CHAR_NINE && entry_len < DIGIT_N) begin
					entry_digit[entry_len] = bcd_t'(ch - CHAR_ZERO);
					entry_len++;
				end
			end
			OP_IDLE: begin
				if (idle_ticks < IDLE_MAX && idle_ticks <= idle_limit) begin
					idle_ticks = idle_ticks + 1'b1;
					if (idle_ticks == idle_limit && entry_len > 0) begin
						// first digit received ends up most significant
						for (int k = 0; k < DIGIT_N; k++)
							count_digit[k] = (k < entry_len) ? entry_digit[entry_len - 1 - k] : '0;
						entry_len = 0;
						r.load    = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		v = 0;
		for (int k = DIGIT_N - 1; k >= 0; k--)
			v = v * 10 + count_digit[k];
		r.seg   = lit_seg;
		r.en    = lit_en;
		r.value = VALUE_W'(v);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_limit = IDLE_LIMIT_RESET;
			for (int k = 0; k < DIGIT_N; k++) begin
				count_digit[k] = '0;
				entry_digit[k] = '0;
			end
			entry_len       = 0;
			scan_pos        = '0;
			idle_ticks      = '0;
			lit_seg         = SEG_BLANK;
			lit_en          = '0;
			display_q.delete();
			fail_count      = 0;
			results_waiting = 0;
			loads_seen      = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				idle_limit = cfg_data;
			// results are registered behind their events, so compare first
			if (out_valid && out_ready) begin
				got = {segment_pattern, digit_enable, shown_value, loaded};
				if (display_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result: seg %h en %b value %0d load %b",
							got.seg, got.en, got.value, got.load);
					fail_count++;
				end else begin
					want = display_q.pop_front();
					if (got.seg !== want.seg || got.en !== want.en ||
							got.value !== want.value || got.load !== want.load) begin
						if (fail_count < 10)
							$display({"mismatch: expected seg %h en %b value %0d load %b, ",
								"got seg %h en %b value %0d load %b"},
								want.seg, want.en, want.value, want.load,
								got.seg, got.en, got.value, got.load);
						fail_count++;
					end
					if (want.load)
						loads_seen++;
				end
			end
			if (in_valid && in_ready)
				display_q.push_back(predict_display(opcode, rx_char));
			results_waiting = display_q.size();
		end
	end

endmodule

[test/countdown_seven_segment_serial_load_tb.sv]
`timescale 1ns / 100ps

// Stimulus and verdict for the countdown display. The checker beside the block
// watches all three channels, keeps its own model of the display and compares
// every result transfer; this module only drives the channels.
module countdown_seven_segment_serial_load_tb;
	import cdss_pkg::*;

	localparam int TOTAL_EVENTS = 1225;     // directed opening plus the random part
	localparam int CYCLE_LIMIT  = 400_000;  // many times the slowest legal run

	// receiver behaviour, re-chosen each time the 8-bit ready_tick wraps to zero
	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_HALF,
		READY_SPARSE,
		READY_PERIODIC
	} ready_mode_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_valid = 1'b0;
	logic [VALUE_W-1:0] cfg_data  = '0;
	logic               in_valid  = 1'b0;
	logic [OP_W-1:0]    opcode    = OP_COUNT;
	logic [CHAR_W-1:0]  rx_char   = '0;
	logic               out_ready = 1'b0;

	logic               cfg_ready;
	logic               in_ready;
	logic               out_valid;
	logic [SEG_W-1:0]   segment_pattern;
	logic [EN_W-1:0]    digit_enable;
	logic [VALUE_W-1:0] shown_value;
	logic               loaded;

	// transfer flags latched at the rising edge, read by the driver at the falling one
	logic               in_took   = 1'b0;
	logic               cfg_took  = 1'b0;

	int                 fail_count;
	int                 results_waiting;
	int                 loads_seen;

	int                 cycle_count = 0;
	int                 events_sent = 0;
	int                 burst_left  = 0;
	int                 settings    = 0;
	logic [7:0]         ready_tick  = '0;
	ready_mode_t        ready_mode  = READY_ALWAYS;

	always #1 clk = ~clk;

	countdown_seven_segment_serial_load i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.rx_char        (rx_char),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.segment_pattern(segment_pattern),
		.digit_enable   (digit_enable),
		.shown_value    (shown_value),
		.loaded         (loaded)
	);

	countdown_display_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.rx_char        (rx_char),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.segment_pattern(segment_pattern),
		.digit_enable   (digit_enable),
		.shown_value    (shown_value),
		.loaded         (loaded),
		.fail_count     (fail_count),
		.results_waiting(results_waiting),
		.loads_seen     (loads_seen)
	);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_took  <= 1'b0;
			cfg_took <= 1'b0;
		end else begin
			in_took  <= in_valid && in_ready;
			cfg_took <= cfg_valid && cfg_ready;
		end
	end

	// Receiver: its own stall pattern, independent of the sender. Full-rate
	// stretches alternate with coin-flip, sparse and periodic back-pressure.
	always @(negedge clk) begin
		ready_tick <= ready_tick + 8'd1;
		if (ready_tick == 8'd0)
			ready_mode <= ready_mode_t'($urandom_range(0, 3));
		case (ready_mode)
			READY_ALWAYS:   out_ready <= 1'b1;
			READY_HALF:     out_ready <= ($urandom_range(0, 1) == 0);
			READY_SPARSE:   out_ready <= ($urandom_range(0, 4) == 0);
			READY_PERIODIC: out_ready <= (ready_tick[1:0] != 2'd3);
			default:        out_ready <= 1'b1;
		endcase
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[countdown_seven_segment_serial_load] ERROR");
			$finish;
		end
	end

	// One event transfer. Called and returning at a falling edge. The sender
	// runs in bursts; between bursts it usually drops valid for a random gap, and a
	// quarter of the time runs straight on so back-to-back stretches occur.
	task automatic send_event(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		opcode   <= op;
		rx_char  <= ch;
		do @(negedge clk); while (!in_took);
		events_sent++;
	endtask

	// count or scan tick; these leave the idle count alone
	task automatic send_filler();
		send_event(($urandom_range(0, 1) == 0) ? OP_COUNT : OP_SCAN, 8'($urandom));
	endtask

	// stop sending and let every outstanding result drain
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (results_waiting != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// register write, only ever with the block idle
	task automatic set_idle_limit(input logic [VALUE_W-1:0] limit);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= limit;
		do @(negedge clk); while (!cfg_took);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	initial begin
		logic [VALUE_W-1:0] limit;
		int                 phase_end;
		int                 idle_run;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed opening, idle limit still at its reset value ---
		// count tick from zero wraps round to 9999
		send_event(OP_COUNT, 8'h00);
		// a full scan round, position wraps back to the units digit
		repeat (4) send_event(OP_SCAN, 8'hFF);
		// non-scan events must repeat the held segments and enable
		send_event(OP_COUNT, 8'h5A);
		// idle tick with an empty buffer: nothing to load
		send_event(OP_IDLE, 8'hA5);
		// digit boundaries and their neighbours, plus both byte extremes
		send_event(OP_CHAR, CHAR_ZERO);
		send_event(OP_CHAR, CHAR_NINE);
		send_event(OP_CHAR, CHAR_ZERO - 8'd1);
		send_event(OP_CHAR, CHAR_NINE + 8'd1);
		send_event(OP_CHAR, 8'h00);
		send_event(OP_CHAR, 8'hFF);
		send_event(OP_CHAR, CHAR_ZERO + 8'd4);
		send_event(OP_CHAR, CHAR_ZERO + 8'd5);
		// buffer already full, this one is dropped
		send_event(OP_CHAR, CHAR_ZERO + 8'd6);
		// short limit: third idle tick loads 0945, the fourth sits past the limit
		set_idle_limit(14'd3);
		repeat (4) send_event(OP_IDLE, 8'($urandom));
		// single buffered digit: upper digits load as zero
		send_event(OP_CHAR, CHAR_ZERO + 8'd7);
		repeat (3) send_event(OP_IDLE, 8'($urandom));
		send_event(OP_SCAN, 8'h3C);

		// --- random part, one idle limit per phase ---
		// Mostly well-formed entries (digits, then enough idle ticks to load),
		// with count and scan ticks sprinkled in; the rest is random noise.
		// Each phase starts with the sender held off until all results are in.
		while (events_sent < TOTAL_EVENTS) begin
			case (settings)
				1:       limit = 14'd1;
				2:       limit = 14'd9000;
				3:       limit = 14'd0;
				4:       limit = 14'd2;
				default: limit = ($urandom_range(0, 4) != 0)
				                 ? VALUE_W'($urandom_range(1, 40))
				                 : VALUE_W'($urandom_range(41, 9000));
			endcase
			set_idle_limit(limit);
			phase_end = events_sent + $urandom_range(60, 160);
			while (events_sent < phase_end) begin
				if ($urandom_range(0, 3) != 0) begin
					repeat ($urandom_range(1, 5)) begin
						if ($urandom_range(0, 3) == 0)
							send_filler();
						if ($urandom_range(0, 7) != 0)
							send_event(OP_CHAR, CHAR_ZERO + 8'($urandom_range(0, 9)));
						else
							send_event(OP_CHAR, 8'($urandom));
					end
					// reach the limit where it is short, else just tick a while
					idle_run = (limit >= 1 && limit <= 60) ? limit + $urandom_range(0, 3)
					                                       : $urandom_range(1, 30);
					repeat (idle_run) begin
						if ($urandom_range(0, 4) == 0)
							send_filler();
						send_event(OP_IDLE, 8'($urandom));
					end
				end else begin
					repeat ($urandom_range(1, 8))
						send_event(OP_W'($urandom_range(0, 3)), 8'($urandom));
				end
			end
		end

		wait_idle();
		repeat (8) @(negedge clk);
		$display("ran %0d events through %0d idle-limit writes (0, 1 and 9000 among them)",
			events_sent, settings);
		$display("%0d of the checked results carried a serial load", loads_seen);
		if (fail_count == 0 && results_waiting == 0)
			$display("[countdown_seven_segment_serial_load] OK");
		else
			$display("[countdown_seven_segment_serial_load] ERROR");
		$finish;
	end

endmodule

[filelist.f]
rtl/cdss_pkg.sv
rtl/cdss_bcd_bin.sv
rtl/countdown_seven_segment_serial_load.sv
test/countdown_display_checker.sv
test/countdown_seven_segment_serial_load_tb.sv
